FILE: hw/rtl/ncm_pkg.sv
// ncm_pkg: shared types, field widths and codes for the nearest color match block
// no dependencies; imported by ncm_ram users, ncm_scan and nearest_color_match

package ncm_pkg;

  localparam int COMP_W          = 8;
  localparam int COLOR_W         = 3 * COMP_W;
  localparam int IDX_W           = 6;
  localparam int DIST_W          = 10;
  localparam int MAX_ENTRIES_DEF = 64;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [COMP_W-1:0] comp0;
    logic [COMP_W-1:0] comp1;
    logic [COMP_W-1:0] comp2;
  } ncm_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } ncm_out_t;

  // scan engine report back to the controller
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } ncm_hit_t;

endpackage

FILE: hw/rtl/ncm_ram.sv
// ncm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ncm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/ncm_scan.sv
// ncm_scan: walks the color table one entry per cycle and keeps the nearest match
// depends on ncm_pkg; drives the read port of the table ram

module ncm_scan #(
  parameter int MAX_ENTRIES = ncm_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [CW-1:0]            count,
  input  ncm_pkg::ncm_in_t         query,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic [ncm_pkg::COLOR_W-1:0] rd_data,
  output ncm_pkg::ncm_hit_t        hit
);

  import ncm_pkg::*;

  logic [CW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     count_r;
  logic              issuing_r, issuing_nxt;
  logic              pend_r;
  logic [AW-1:0]     pend_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [AW-1:0]     best_idx_r;
  logic              done_r;
  ncm_in_t           qry_r;
  logic [DIST_W-1:0] cur_dist;

  function automatic logic [DIST_W-1:0] manhattan(
    input logic [COLOR_W-1:0] e,
    input ncm_in_t            q
  );
    logic [COMP_W-1:0] d0, d1, d2;
    d0 = (e[7:0]   > q.comp0) ? (e[7:0]   - q.comp0) : (q.comp0 - e[7:0]);
    d1 = (e[15:8]  > q.comp1) ? (e[15:8]  - q.comp1) : (q.comp1 - e[15:8]);
    d2 = (e[23:16] > q.comp2) ? (e[23:16] - q.comp2) : (q.comp2 - e[23:16]);
    return DIST_W'(d0) + DIST_W'(d1) + DIST_W'(d2);
  endfunction

  assign cur_dist = manhattan(rd_data, qry_r);
  assign rd_en    = issuing_r;
  assign rd_addr  = addr_r[AW-1:0];

  always_comb begin
    addr_nxt    = addr_r;
    issuing_nxt = issuing_r;
    if (start) begin
      addr_nxt    = '0;
      issuing_nxt = 1'b1;
    end else if (issuing_r) begin
      addr_nxt = CW'(addr_r + 1'b1);
      if (CW'(addr_r + 1'b1) == count_r) begin
        issuing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      issuing_r <= issuing_nxt;
      pend_r    <= issuing_r;
      done_r    <= pend_r && !issuing_r;
    end
    addr_r     <= addr_nxt;
    pend_idx_r <= addr_r[AW-1:0];
    if (start) begin
      count_r     <= count;
      qry_r       <= query;
      // all ones exceeds any real distance, so entry 0 always wins first
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (pend_r && (cur_dist < best_dist_r)) begin
      best_dist_r <= cur_dist;
      best_idx_r  <= pend_idx_r;
    end
  end

  assign hit.done     = done_r;
  assign hit.index    = IDX_W'(best_idx_r);
  assign hit.distance = best_dist_r;

endmodule

FILE: hw/rtl/nearest_color_match.sv
// nearest_color_match: top level, item decode, table count and result register
// depends on ncm_pkg, ncm_ram and ncm_scan

// Nearest color match keeps a table of up to MAX_ENTRIES colors (three 8-bit
// components each) in a single ram and answers one item at a time. An item
// either clears the table, appends a color at the next free index, or asks
// for the stored entry with the least Manhattan distance to a given color;
// ties go to the lowest index. Each item gives exactly one result transfer.
// Clear, append and unused codes go straight to the result register. In a
// query the ram read port is walked one entry per cycle, followed by the
// registered ram read, the scan done flag and the load of the result
// register. The input reopens once the result has moved into the output
// register, so a new item is taken only after the last one is through. A
// query on an empty table returns the empty status at once; an append to a
// full table is dropped with the full status. The result register lets the
// block take the next item while a finished result is still stalled at the
// output. The block needs no clearing pass after reset: only entries below
// the count are ever read, and an append always finishes its write before
// the next query starts reading, so no forwarding is needed.

module nearest_color_match #(
  parameter int MAX_ENTRIES = ncm_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ncm_pkg::ncm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ncm_pkg::ncm_out_t out_data
);

  import ncm_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  ncm_out_t res_r, res_nxt;
  logic     out_valid_r, out_valid_nxt;
  ncm_out_t out_data_r, out_data_nxt;

  // table write side (appends)
  logic               wr_en;
  logic [COLOR_W-1:0] wr_data;

  // scan engine hookup
  logic               scan_start;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COLOR_W-1:0] rd_data;
  ncm_hit_t           hit;

  logic in_xfer;
  logic table_full;

  assign in_xfer    = in_valid && !in_stall;
  assign table_full = (count_r == CW'(MAX_ENTRIES));
  assign wr_data    = {in_data.comp2, in_data.comp1, in_data.comp0};

  ncm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ncm_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .count   (count_r),
    .query   (in_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .hit     (hit)
  );

  // one item in flight; input is open only when idle
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    scan_start    = 1'b0;

    // output register drains on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt   = '0;
          state_nxt = S_HOLD;
          unique case (in_data.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (table_full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en              = 1'b1;
                res_nxt.best_index = IDX_W'(count_r);
                count_nxt          = CW'(count_r + 1'b1);
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                scan_start = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              // unused code: table left unchanged, all-zero result
              res_nxt = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit.done) begin
          res_nxt.status        = ST_OK;
          res_nxt.best_index    = hit.index;
          res_nxt.best_distance = hit.distance;
          state_nxt             = S_HOLD;
        end
      end
      S_HOLD: begin
        // wait for the output register to be free (or freed this cycle)
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  // scan finishes only while the controller waits for it
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    hit.done |-> state_r == S_SCAN)
    else $error("scan done outside of scan state");

  // an accepted item closes the input until its result is loaded into the output register
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input open right after a transfer");

  // no table write while the table is being walked
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("table write during scan");

endmodule

FILE: tb/tb_nearest_color_match.sv
`timescale 1ns / 100ps
// tb_nearest_color_match: self-checking testbench for the nearest color match block
// depends on ncm_pkg and nearest_color_match; needs no files or arguments

module tb_nearest_color_match;

  import ncm_pkg::*;

  // op code 3 is not decoded by the block; it must leave the table alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
  // covers a full-table query, with room for a stalled result on top
  localparam int SETTLE_CYCLES = 100;
  // worst run: ~650 items, each with its idle and stall bursts, plus long holds
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ncm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ncm_out_t out_data;

  // shadow of the block: stored colors (comp0 in the low byte) and fill level
  logic [COLOR_W-1:0] color_mem [TABLE_DEPTH];
  int                 stored_count = 0;

  // results still owed by the block, oldest first
  ncm_out_t expected_matches [$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int cycle_count     = 0;
  // random idling on both sides is switched off for the closing stretch
  bit idle_on         = 1'b1;
  // request for one long receiver hold-off, taken up by the receiver process
  int hold_off_cycles = 0;

  nearest_color_match DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_matches.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned comp_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Manhattan distance between a stored color and the query color
  function automatic int unsigned color_distance(logic [COLOR_W-1:0] entry, ncm_in_t q);
    return comp_gap(entry[7:0], q.comp0) + comp_gap(entry[15:8], q.comp1)
         + comp_gap(entry[23:16], q.comp2);
  endfunction

  // applies one accepted transfer to the shadow table and returns its result
  function automatic ncm_out_t predict_match(ncm_in_t item);
    ncm_out_t    res;
    int unsigned best_dist;
    int unsigned cand_dist;
    int          best_idx;
    res = '0;
    case (item.op)
      OP_CLEAR: stored_count = 0;
      OP_APPEND: begin
        if (stored_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          color_mem[stored_count] = {item.comp2, item.comp1, item.comp0};
          res.best_index = IDX_W'(stored_count);
          stored_count++;
        end
      end
      OP_QUERY: begin
        if (stored_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best_dist = color_distance(color_mem[0], item);
          best_idx  = 0;
          // strict less-than keeps the lowest index on ties
          for (int i = 1; i < stored_count; i++) begin
            cand_dist = color_distance(color_mem[i], item);
            if (cand_dist < best_dist) begin
              best_dist = cand_dist;
              best_idx  = i;
            end
          end
          res.best_index    = IDX_W'(best_idx);
          res.best_distance = DIST_W'(best_dist);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_error(string what, ncm_out_t want, ncm_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected status/index/distance %0d/%0d/%0d, got %0d/%0d/%0d",
               $time, what, want.status, want.best_index, want.best_distance,
               got.status, got.best_index, got.best_distance);
  endtask

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin
    ncm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        note_error("result transfer with nothing owed", '0, out_data);
      end else begin
        want = expected_matches.pop_front();
        if (out_data.status !== want.status || out_data.best_index !== want.best_index ||
            out_data.best_distance !== want.best_distance)
          note_error("result mismatch", want, out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver_side
    int span;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        span = hold_off_cycles;
        hold_off_cycles = 0;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rst_n && idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the transfer edge, or after an idle burst if one is drawn.
  // valid stays high for a follow-on item unless an idle burst is drawn
  task automatic send_item(ncm_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_matches = {expected_matches, predict_match(item)};
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // ends a stream of items; valid must not stay up with an old payload
  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // sender pause until the block has delivered every owed result
  task automatic wait_results_done();
    drop_valid();
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  function automatic ncm_in_t item_of(logic [1:0] op, logic [7:0] c0, logic [7:0] c1,
                                      logic [7:0] c2);
    ncm_in_t item;
    item.op    = op;
    item.comp0 = c0;
    item.comp1 = c1;
    item.comp2 = c2;
    return item;
  endfunction

  // component values lean toward the two extremes
  function automatic logic [7:0] pick_component();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic ncm_in_t random_item(logic [1:0] op);
    return item_of(op, pick_component(), pick_component(), pick_component());
  endfunction

  // queries mostly land near a stored color so the winner is not trivial
  function automatic ncm_in_t query_item();
    int k;
    if (stored_count > 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, stored_count - 1);
      return item_of(OP_QUERY, nudge(color_mem[k][7:0]), nudge(color_mem[k][15:8]),
                     nudge(color_mem[k][23:16]));
    end
    return random_item(OP_QUERY);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, every op code, empty table, ties and the largest distance
  task automatic test_directed();
    send_item(item_of(OP_QUERY, 8'h00, 8'h00, 8'h00));      // query right after reset
    send_item(item_of(OP_UNUSED, 8'hff, 8'hff, 8'hff));     // unused code on empty table
    send_item(item_of(OP_APPEND, 8'h00, 8'h00, 8'h00));
    send_item(item_of(OP_QUERY, 8'hff, 8'hff, 8'hff));      // largest distance
    send_item(item_of(OP_APPEND, 8'hff, 8'hff, 8'hff));
    send_item(item_of(OP_APPEND, 8'h00, 8'h00, 8'h00));     // duplicate, loses ties
    send_item(item_of(OP_QUERY, 8'h00, 8'h00, 8'h00));
    send_item(item_of(OP_QUERY, 8'hff, 8'hff, 8'hff));
    send_item(item_of(OP_QUERY, 8'd128, 8'd128, 8'd127));   // just past the midpoint
    send_item(item_of(OP_APPEND, 8'd10, 8'd20, 8'd30));
    send_item(item_of(OP_APPEND, 8'd30, 8'd20, 8'd10));
    send_item(item_of(OP_QUERY, 8'd20, 8'd20, 8'd20));      // equal distance tie
    send_item(item_of(OP_APPEND, 8'hff, 8'h00, 8'h00));
    send_item(item_of(OP_APPEND, 8'h00, 8'hff, 8'h00));
    send_item(item_of(OP_APPEND, 8'h00, 8'h00, 8'hff));
    send_item(item_of(OP_QUERY, 8'd250, 8'd5, 8'd0));
    send_item(item_of(OP_QUERY, 8'd3, 8'd240, 8'd9));
    send_item(item_of(OP_QUERY, 8'd0, 8'd7, 8'd255));
    send_item(item_of(OP_UNUSED, 8'h00, 8'h00, 8'h00));     // unused code, table kept
    send_item(item_of(OP_QUERY, 8'd31, 8'd19, 8'd11));
    send_item(item_of(OP_CLEAR, 8'hff, 8'hff, 8'hff));
    send_item(item_of(OP_QUERY, 8'd1, 8'd2, 8'd3));         // empty again after clear
    send_item(item_of(OP_APPEND, 8'h5a, 8'ha5, 8'h3c));     // index restarts at 0
    send_item(item_of(OP_QUERY, 8'h5a, 8'ha5, 8'h3c));
    wait_results_done();
  endtask

  // fills all entries, then overflows and scans the full table
  task automatic test_full_table();
    send_item(item_of(OP_CLEAR, 8'h00, 8'h00, 8'h00));
    repeat (TABLE_DEPTH) send_item(random_item(OP_APPEND));
    send_item(item_of(OP_APPEND, 8'hff, 8'hff, 8'hff));     // dropped, table full
    send_item(random_item(OP_APPEND));
    send_item(item_of(OP_QUERY, color_mem[TABLE_DEPTH-1][7:0],
                      color_mem[TABLE_DEPTH-1][15:8], color_mem[TABLE_DEPTH-1][23:16]));
    send_item(item_of(OP_QUERY, color_mem[0][7:0], color_mem[0][15:8], color_mem[0][23:16]));
    send_item(item_of(OP_QUERY, 8'h00, 8'h00, 8'h00));
    send_item(item_of(OP_QUERY, 8'hff, 8'hff, 8'hff));
    repeat (6) send_item(query_item());
    send_item(random_item(OP_UNUSED));
    send_item(random_item(OP_APPEND));                      // still full
    wait_results_done();
  endtask

  // output held off for a long stretch while items keep coming, so the
  // output register and the result register both fill and the input stalls
  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_off_cycles = 300;
    while (!out_stall) @(posedge clk);
    repeat (3) send_item(query_item());
    repeat (4) send_item(random_item(OP_APPEND));
    send_item(random_item(OP_UNUSED));
    repeat (2) send_item(query_item());
    wait_results_done();
    idle_on = 1'b1;
  endtask

  // sessions of an optional clear, a fill to a random level, then a mix of appends, queries, clears and unused codes
  task automatic test_random_sessions(int n_items);
    int stop_at;
    int fill;
    int mix_len;
    int r;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      // some sessions run with no idling at all
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0)
        send_item(random_item(OP_CLEAR));
      // mostly small tables; now and then fill past the end
      fill = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 12);
      repeat (fill) send_item(random_item(OP_APPEND));
      mix_len = $urandom_range(5, 30);
      repeat (mix_len) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          send_item(random_item(OP_UNUSED));
        else if (r < 7)
          send_item(random_item(OP_CLEAR));
        else if (r < 35)
          send_item(random_item(OP_APPEND));
        else
          send_item(query_item());
      end
    end
    idle_on = 1'b1;
    wait_results_done();
  endtask

  // closing stretch: back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_item(random_item(OP_CLEAR));
    repeat (10) send_item(random_item(OP_APPEND));
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_item(random_item(OP_APPEND));
      else
        send_item(query_item());
    end
    drop_valid();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_output_hold();
    test_random_sessions(440);
    test_steady_stream();

    wait_results_done();
    // late or extra result transfers still get caught by the checker
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
